### design/ewcm_pkg.sv
// Package for the energy-weighted circular mean core: widths, fixed-point
// constants, the arctangent table and the control structs shared by the modules.
// No dependencies.
package ewcm_pkg;

	localparam int CNT_W = 8;
	localparam logic [CNT_W-1:0] MAX_SAMPLES = 8'd255;

	localparam int SUM_W = 56;
	localparam int MAG_W = 56;
	localparam int CW    = 59;
	localparam int ZW    = 27;

	localparam logic [15:0] ANGLE_FULL = 16'd36000;
	localparam logic [15:0] ANGLE_Q1   = 16'd9000;
	localparam logic [15:0] ANGLE_Q2   = 16'd18000;
	localparam logic [15:0] ANGLE_Q3   = 16'd27000;

	localparam logic signed [CW-1:0] GAIN_Q30 = 59'sd652032874;
	localparam logic [4:0] CORDIC_LAST = 5'd17;

	localparam logic [17:0] PHI_RIGHT  = 18'd144000;
	localparam logic [19:0] DIR16_HALF = 20'd288000;
	localparam logic [19:0] DIR16_FULL = 20'd576000;

	localparam int MD_W  = 49;
	localparam int MD_QW = 25;
	localparam int MD_RW = 31;
	localparam logic [4:0] MD_LAST = 5'd24;
	localparam logic [MD_RW-1:0] PI_Q29      = 31'd1686629713;
	localparam logic [MD_RW-1:0] DIV_TO_RAD  = 31'd576000;
	localparam logic [MD_W-1:0]  ADD_TO_RAD  = 49'd288000;
	localparam logic [MD_W-1:0]  MUL_TO_DIR  = 49'd9216000;

	typedef enum logic [0:0] {
		MD_TO_RAD = 1'b0,
		MD_TO_DIR = 1'b1
	} md_mode_t;

	typedef struct packed {
		logic     start;
		md_mode_t mode;
	} md_ctl_t;

	typedef struct packed {
		logic start;
		logic vectoring;
	} cd_ctl_t;

	function automatic logic signed [ZW-1:0] atan_q24(input logic [4:0] i);
		unique case (i)
			5'd0:    atan_q24 = 27'sd13176795;
			5'd1:    atan_q24 = 27'sd7778716;
			5'd2:    atan_q24 = 27'sd4110060;
			5'd3:    atan_q24 = 27'sd2086331;
			5'd4:    atan_q24 = 27'sd1047214;
			5'd5:    atan_q24 = 27'sd524117;
			5'd6:    atan_q24 = 27'sd262123;
			5'd7:    atan_q24 = 27'sd131069;
			5'd8:    atan_q24 = 27'sd65536;
			5'd9:    atan_q24 = 27'sd32768;
			5'd10:   atan_q24 = 27'sd16384;
			5'd11:   atan_q24 = 27'sd8192;
			5'd12:   atan_q24 = 27'sd4096;
			5'd13:   atan_q24 = 27'sd2048;
			5'd14:   atan_q24 = 27'sd1024;
			5'd15:   atan_q24 = 27'sd512;
			5'd16:   atan_q24 = 27'sd256;
			5'd17:   atan_q24 = 27'sd128;
			default: atan_q24 = 27'sd0;
		endcase
	endfunction

endpackage

### design/ewcm_in_if.sv
// Sample request channel of the energy-weighted circular mean core.
// Stand-alone valid/ready interface; no dependencies.
interface ewcm_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] height;
	logic        height_valid;
	logic [15:0] angle;
	logic        angle_valid;
	logic        last_sample;

	modport source (output valid, height, height_valid, angle, angle_valid, last_sample,
		input ready);
	modport sink (input valid, height, height_valid, angle, angle_valid, last_sample,
		output ready);
endinterface

### design/ewcm_out_if.sv
// Result request channel of the energy-weighted circular mean core.
// Stand-alone valid/ready interface; no dependencies.
interface ewcm_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] direction;
	logic        direction_valid;

	modport source (output valid, direction, direction_valid, input ready);
	modport sink (input valid, direction, direction_valid, output ready);
endinterface

### design/ewcm_muldiv.sv
// Serial multiply-then-divide by constants, one bit per cycle in each phase.
// Depends on ewcm_pkg.
module ewcm_muldiv
	import ewcm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  md_ctl_t          ctl,
	input  logic [MD_QW-1:0] operand,
	output logic             done,
	output logic [MD_QW-1:0] quotient
);

	typedef enum logic [2:0] {
		MD_IDLE = 3'b001,
		MD_MUL  = 3'b010,
		MD_DIV  = 3'b100
	} md_state_t;

	md_state_t         state_q;
	md_mode_t          mode_q;
	logic [4:0]        cnt_q;
	logic [MD_QW-1:0]  mplier_q;
	logic [MD_W-1:0]   mcand_q;
	logic [MD_W-1:0]   acc_q;
	logic [MD_RW-1:0]  rem_q;
	logic [MD_QW-1:0]  quo_q;
	logic              done_q;

	logic [MD_W-1:0]   acc_nxt;
	logic [MD_RW-1:0]  divisor;
	logic [MD_RW:0]    trial;
	logic              fits;

	assign acc_nxt = acc_q + (mplier_q[0] ? mcand_q : '0);
	assign divisor = (mode_q == MD_TO_RAD) ? DIV_TO_RAD : PI_Q29;
	assign trial   = {rem_q, quo_q[MD_QW-1]};
	assign fits    = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MD_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				state_q <= MD_MUL;
				cnt_q   <= '0;
			end else begin
				unique case (state_q)
					MD_IDLE: ;
					MD_MUL: begin
						cnt_q <= cnt_q + 5'd1;
						if (cnt_q == MD_LAST) begin
							state_q <= MD_DIV;
							cnt_q   <= '0;
						end
					end
					MD_DIV: begin
						cnt_q <= cnt_q + 5'd1;
						if (cnt_q == MD_LAST) begin
							state_q <= MD_IDLE;
							done_q  <= 1'b1;
						end
					end
					default: state_q <= MD_IDLE;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			mode_q   <= ctl.mode;
			mplier_q <= operand;
			mcand_q  <= (ctl.mode == MD_TO_RAD) ? MD_W'(PI_Q29) : MUL_TO_DIR;
			acc_q    <= (ctl.mode == MD_TO_RAD) ? ADD_TO_RAD : '0;
		end else if (state_q == MD_MUL) begin
			acc_q    <= acc_nxt;
			mcand_q  <= {mcand_q[MD_W-2:0], 1'b0};
			mplier_q <= {1'b0, mplier_q[MD_QW-1:1]};
			if (cnt_q == MD_LAST) begin
				// The numerator is small enough that its top part is already below the divisor.
				rem_q <= MD_RW'(acc_nxt[MD_W-1:MD_QW]);
				quo_q <= acc_nxt[MD_QW-1:0];
			end
		end else if (state_q == MD_DIV) begin
			rem_q <= fits ? MD_RW'(trial - {1'b0, divisor}) : trial[MD_RW-1:0];
			quo_q <= {quo_q[MD_QW-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

### design/ewcm_cordic.sv
// Iterative CORDIC, one micro-rotation per cycle, in rotation or vectoring mode.
// Depends on ewcm_pkg.
module ewcm_cordic
	import ewcm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  cd_ctl_t              ctl,
	input  logic signed [CW-1:0] x0,
	input  logic signed [CW-1:0] y0,
	input  logic signed [ZW-1:0] z0,
	output logic                 done,
	output logic signed [CW-1:0] x,
	output logic signed [CW-1:0] y,
	output logic signed [ZW-1:0] z
);

	logic                 run_q;
	logic                 done_q;
	logic                 vec_q;
	logic [4:0]           step_q;
	logic signed [CW-1:0] x_q;
	logic signed [CW-1:0] y_q;
	logic signed [ZW-1:0] z_q;

	logic signed [CW-1:0] dx;
	logic signed [CW-1:0] dy;
	logic signed [ZW-1:0] da;
	logic                 up;

	assign dx = y_q >>> step_q;
	assign dy = x_q >>> step_q;
	assign da = atan_q24(step_q);
	// Rotation drives z towards zero, vectoring drives y towards zero.
	assign up = vec_q ? y_q[CW-1] : !z_q[ZW-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + 5'd1;
				if (step_q == CORDIC_LAST) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			vec_q <= ctl.vectoring;
			x_q   <= x0;
			y_q   <= y0;
			z_q   <= z0;
		end else if (run_q) begin
			if (up) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - da;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + da;
			end
		end
	end

	assign done = done_q;
	assign x    = x_q;
	assign y    = y_q;
	assign z    = z_q;

endmodule

### design/ewcm_wmac.sv
// Bit-serial squaring of the height and weighted accumulation of sine and cosine.
// Holds the two running sums. Depends on ewcm_pkg.
module ewcm_wmac
	import ewcm_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic                    clear,
	input  logic [15:0]             height,
	input  logic signed [15:0]      sin_v,
	input  logic signed [15:0]      cos_v,
	output logic                    done,
	output logic signed [SUM_W-1:0] sine_sum,
	output logic signed [SUM_W-1:0] cosine_sum
);

	typedef enum logic [3:0] {
		WM_IDLE = 4'b0001,
		WM_SQ   = 4'b0010,
		WM_LOAD = 4'b0100,
		WM_ACC  = 4'b1000
	} wm_state_t;

	wm_state_t               state_q;
	logic [3:0]              k_q;
	logic                    done_q;
	logic [15:0]             hmul_q;
	logic [31:0]             hsh_q;
	logic [31:0]             w_q;
	logic [47:0]             wsh_q;
	logic [15:0]             sv_q;
	logic [15:0]             cv_q;
	logic signed [SUM_W-1:0] ssum_q;
	logic signed [SUM_W-1:0] csum_q;

	logic signed [SUM_W-1:0] term;
	logic                    sign_bit;

	assign term     = {{(SUM_W-48){1'b0}}, wsh_q};
	assign sign_bit = (k_q == 4'd15);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= WM_IDLE;
			k_q     <= '0;
			done_q  <= 1'b0;
			ssum_q  <= '0;
			csum_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (clear) begin
				ssum_q <= '0;
				csum_q <= '0;
			end
			if (start) begin
				state_q <= WM_SQ;
				k_q     <= '0;
			end else begin
				unique case (state_q)
					WM_IDLE: ;
					WM_SQ: begin
						k_q <= k_q + 4'd1;
						if (k_q == 4'd15) begin
							state_q <= WM_LOAD;
						end
					end
					WM_LOAD: begin
						k_q     <= '0;
						state_q <= WM_ACC;
					end
					WM_ACC: begin
						k_q <= k_q + 4'd1;
						// The top bit of a two's complement factor weighs negative.
						if (sv_q[0]) begin
							ssum_q <= sign_bit ? ssum_q - term : ssum_q + term;
						end
						if (cv_q[0]) begin
							csum_q <= sign_bit ? csum_q - term : csum_q + term;
						end
						if (k_q == 4'd15) begin
							state_q <= WM_IDLE;
							done_q  <= 1'b1;
						end
					end
					default: state_q <= WM_IDLE;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			hmul_q <= height;
			hsh_q  <= {16'b0, height};
			w_q    <= '0;
			sv_q   <= sin_v;
			cv_q   <= cos_v;
		end else if (state_q == WM_SQ) begin
			if (hmul_q[0]) begin
				w_q <= w_q + hsh_q;
			end
			hsh_q  <= {hsh_q[30:0], 1'b0};
			hmul_q <= {1'b0, hmul_q[15:1]};
		end else if (state_q == WM_LOAD) begin
			wsh_q <= {16'b0, w_q};
		end else if (state_q == WM_ACC) begin
			wsh_q <= {wsh_q[46:0], 1'b0};
			sv_q  <= {1'b0, sv_q[15:1]};
			cv_q  <= {1'b0, cv_q[15:1]};
		end
	end

	assign done       = done_q;
	assign sine_sum   = ssum_q;
	assign cosine_sum = csum_q;

endmodule

### design/energy_weighted_circular_mean_core.sv
// Top level of the energy-weighted circular mean core. Depends on ewcm_pkg,
// ewcm_in_if, ewcm_out_if, ewcm_muldiv, ewcm_cordic and ewcm_wmac.
//
// The core takes a run of samples for one grid cell, each a height in millimetres
// and a direction in hundredths of a degree, and on the sample flagged last returns
// one request holding the height-squared weighted mean direction (0..35999,
// clockwise from north) and a flag that is set when the number of usable samples
// seen reaches the configured threshold. A sample is usable when both its presence
// flags are set; at most 255 usable samples are counted per run and the rest are
// ignored. The core works on one sample at a time. A sample that is neither usable
// nor last only passes the end-of-run check. A usable sample goes through the serial
// angle-to-radian conversion (a shift-add multiply and a restoring divide), the
// rotation CORDIC that yields sine and cosine, the bit-serial squaring of the height,
// a load and the accumulation into the two 56-bit sums, with a hand-over between
// the units. When the threshold is met and both sums are nonzero, the last sample of
// a run then goes through normalisation (one bit per cycle), the 18 vectoring CORDIC
// steps and another serial multiply and divide that turns the angle into sixteenths
// of a hundredth; the direction is then placed in its quadrant and passed to the
// output register. The sample port is ready whenever the core is idle; a finished
// result waits in an output register, so a new run may start while the previous
// request has not yet been taken, and the core only stalls when a second result
// finds that register still full. The threshold resets to 1 and is written through
// cfg_we and cfg_wdata; the user must write it only while the core is idle, as the
// core itself does not enforce this.
module energy_weighted_circular_mean_core
	import ewcm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CNT_W-1:0]  cfg_wdata,
	ewcm_in_if.sink           samples,
	ewcm_out_if.source        result
);

	typedef enum logic [9:0] {
		ST_IDLE = 10'b0000000001,
		ST_CONV = 10'b0000000010,
		ST_ROT  = 10'b0000000100,
		ST_MAC  = 10'b0000001000,
		ST_LAST = 10'b0000010000,
		ST_NORM = 10'b0000100000,
		ST_VEC  = 10'b0001000000,
		ST_PHI  = 10'b0010000000,
		ST_QUAD = 10'b0100000000,
		ST_OUT  = 10'b1000000000
	} st_t;

	st_t state_q;

	// Configuration and run state.
	logic [CNT_W-1:0] min_q;
	logic [CNT_W-1:0] count_q;

	// The sample in work.
	logic [15:0]      h_q;
	logic             last_q;
	logic [1:0]       quad_q;
	logic signed [15:0] s_q;
	logic signed [15:0] c_q;

	// Final direction search.
	logic [MAG_W-1:0] ax_q;
	logic [MAG_W-1:0] ay_q;
	logic             xneg_q;
	logic             yneg_q;
	logic [17:0]      phi_q;

	// Result waiting for the outgoing request.
	logic [15:0]      res_dir_q;
	logic             res_ok_q;
	logic [15:0]      out_dir_q;
	logic             out_ok_q;
	logic             out_valid_q;

	// Start pulses towards the serial units.
	logic             md_start_q;
	md_mode_t         md_mode_q;
	logic [MD_QW-1:0] md_opd_q;
	logic             cd_start_q;
	logic             cd_vec_q;
	logic             mac_start_q;

	md_ctl_t              md_ctl;
	logic                 md_done;
	logic [MD_QW-1:0]     md_quo;
	cd_ctl_t              cd_ctl;
	logic                 cd_done;
	logic signed [CW-1:0] cd_x0;
	logic signed [CW-1:0] cd_y0;
	logic signed [ZW-1:0] cd_z0;
	logic signed [CW-1:0] cd_x;
	logic signed [CW-1:0] cd_y;
	logic signed [ZW-1:0] cd_z;
	logic                 mac_done;
	logic                 mac_clear;
	logic signed [SUM_W-1:0] sine_sum;
	logic signed [SUM_W-1:0] cosine_sum;

	// Sample decode at acceptance.
	logic             take;
	logic [15:0]      a_red;
	logic [1:0]       quad_n;
	logic [15:0]      r_n;
	logic             usable;

	// Sine and cosine from the rotation result.
	logic [14:0]        y_rnd;
	logic [14:0]        x_rnd;
	logic signed [15:0] s_pos;
	logic signed [15:0] c_pos;
	logic signed [15:0] s_n;
	logic signed [15:0] c_n;

	// Magnitudes of the sums.
	logic [MAG_W-1:0] sraw;
	logic [MAG_W-1:0] craw;
	logic [MAG_W-1:0] ay_n;
	logic [MAG_W-1:0] ax_n;
	logic [MAG_W-1:0] mag_or;

	// Direction assembly.
	logic [19:0] d16;
	logic [19:0] d16_rnd;
	logic [15:0] d_raw;
	logic [15:0] d_fin;

	logic out_free;

	function automatic logic [14:0] round_q15(input logic signed [CW-1:0] v);
		logic signed [CW-1:0] t;
		logic [CW-16:0]       sh;
		t  = v + CW'(16384);
		sh = t[CW-1:15];
		if (v[CW-1]) begin
			round_q15 = '0;
		end else if (|sh[CW-16:15]) begin
			round_q15 = 15'h7FFF;
		end else begin
			round_q15 = sh[14:0];
		end
	endfunction

	// ---------------------------------------------------------------------------
	// Sample decode. The angle is reduced modulo a full turn, which for a 16-bit
	// field needs one subtraction, and split into a quadrant and a remainder.
	// ---------------------------------------------------------------------------
	assign take  = samples.valid && (state_q == ST_IDLE);
	assign a_red = (samples.angle >= ANGLE_FULL) ? samples.angle - ANGLE_FULL
		: samples.angle;

	always_comb begin
		if (a_red >= ANGLE_Q3) begin
			quad_n = 2'd3;
			r_n    = a_red - ANGLE_Q3;
		end else if (a_red >= ANGLE_Q2) begin
			quad_n = 2'd2;
			r_n    = a_red - ANGLE_Q2;
		end else if (a_red >= ANGLE_Q1) begin
			quad_n = 2'd1;
			r_n    = a_red - ANGLE_Q1;
		end else begin
			quad_n = 2'd0;
			r_n    = a_red;
		end
	end

	assign usable = samples.height_valid && samples.angle_valid && (count_q < MAX_SAMPLES);

	// ---------------------------------------------------------------------------
	// Rounded first-quadrant sine and cosine, then placed in the sample's quadrant.
	// ---------------------------------------------------------------------------
	assign y_rnd = round_q15(cd_y);
	assign x_rnd = round_q15(cd_x);
	assign s_pos = {1'b0, y_rnd};
	assign c_pos = {1'b0, x_rnd};

	always_comb begin
		case (quad_q)
			2'd0: begin
				s_n = s_pos;
				c_n = c_pos;
			end
			2'd1: begin
				s_n = c_pos;
				c_n = -s_pos;
			end
			2'd2: begin
				s_n = -s_pos;
				c_n = -c_pos;
			end
			default: begin
				s_n = -c_pos;
				c_n = s_pos;
			end
		endcase
	end

	// ---------------------------------------------------------------------------
	// Magnitudes of the sums for the vectoring pass.
	// ---------------------------------------------------------------------------
	assign sraw   = sine_sum;
	assign craw   = cosine_sum;
	assign ay_n   = sraw[MAG_W-1] ? (~sraw + MAG_W'(1)) : sraw;
	assign ax_n   = craw[MAG_W-1] ? (~craw + MAG_W'(1)) : craw;
	assign mag_or = ax_q | ay_q;

	// ---------------------------------------------------------------------------
	// First-quadrant angle in sixteenths of a hundredth, mapped to the full circle
	// by the signs of the sums, then rounded half up to hundredths. A result that
	// rounds to a full turn wraps to north.
	// ---------------------------------------------------------------------------
	always_comb begin
		if (!xneg_q && !yneg_q) begin
			d16 = {2'b0, phi_q};
		end else if (xneg_q && !yneg_q) begin
			d16 = DIR16_HALF - {2'b0, phi_q};
		end else if (xneg_q) begin
			d16 = DIR16_HALF + {2'b0, phi_q};
		end else begin
			d16 = DIR16_FULL - {2'b0, phi_q};
		end
	end

	assign d16_rnd = d16 + 20'd8;
	assign d_raw   = d16_rnd[19:4];
	assign d_fin   = (d_raw >= ANGLE_FULL) ? d_raw - ANGLE_FULL : d_raw;

	assign out_free = !out_valid_q || result.ready;

	// ---------------------------------------------------------------------------
	// Sequencer.
	// ---------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			min_q       <= 8'd1;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			md_start_q  <= 1'b0;
			cd_start_q  <= 1'b0;
			mac_start_q <= 1'b0;
		end else begin
			md_start_q  <= 1'b0;
			cd_start_q  <= 1'b0;
			mac_start_q <= 1'b0;

			if (cfg_we) begin
				min_q <= cfg_wdata;
			end

			// A new result may enter in the same cycle as the waiting one is taken.
			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && result.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						if (usable) begin
							md_start_q <= 1'b1;
							state_q    <= ST_CONV;
						end else begin
							state_q <= ST_LAST;
						end
					end
				end
				ST_CONV: begin
					if (md_done) begin
						cd_start_q <= 1'b1;
						state_q    <= ST_ROT;
					end
				end
				ST_ROT: begin
					if (cd_done) begin
						mac_start_q <= 1'b1;
						state_q     <= ST_MAC;
					end
				end
				ST_MAC: begin
					if (mac_done) begin
						count_q <= count_q + CNT_W'(1);
						state_q <= ST_LAST;
					end
				end
				ST_LAST: begin
					if (!last_q) begin
						state_q <= ST_IDLE;
					end else begin
						// The run ends here; the sums are sampled now and cleared behind.
						count_q <= '0;
						if (count_q < min_q) begin
							state_q <= ST_OUT;
						end else if (ax_n == '0 && ay_n == '0) begin
							state_q <= ST_OUT;
						end else if (ay_n == '0 || ax_n == '0) begin
							state_q <= ST_QUAD;
						end else begin
							state_q <= ST_NORM;
						end
					end
				end
				ST_NORM: begin
					if (mag_or[MAG_W-1:MAG_W-2] != 2'b00) begin
						cd_start_q <= 1'b1;
						state_q    <= ST_VEC;
					end
				end
				ST_VEC: begin
					if (cd_done) begin
						md_start_q <= 1'b1;
						state_q    <= ST_PHI;
					end
				end
				ST_PHI: begin
					if (md_done) begin
						state_q <= ST_QUAD;
					end
				end
				ST_QUAD: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers; they need no reset.
	always_ff @(posedge clk) begin
		if (take) begin
			h_q      <= samples.height;
			last_q   <= samples.last_sample;
			quad_q   <= quad_n;
			md_opd_q <= MD_QW'(r_n);
			md_mode_q <= MD_TO_RAD;
			cd_vec_q <= 1'b0;
		end

		if (state_q == ST_ROT && cd_done) begin
			s_q <= s_n;
			c_q <= c_n;
		end

		if (state_q == ST_LAST && last_q) begin
			ax_q      <= ax_n;
			ay_q      <= ay_n;
			xneg_q    <= craw[MAG_W-1];
			yneg_q    <= sraw[MAG_W-1];
			res_dir_q <= '0;
			res_ok_q  <= (count_q >= min_q);
			// A zero sine sum lies on the axis, a zero cosine sum at a right angle.
			phi_q     <= (ay_n == '0) ? '0 : PHI_RIGHT;
		end

		if (state_q == ST_NORM) begin
			if (mag_or[MAG_W-1:MAG_W-2] == 2'b00) begin
				ax_q <= {ax_q[MAG_W-2:0], 1'b0};
				ay_q <= {ay_q[MAG_W-2:0], 1'b0};
			end else begin
				cd_vec_q <= 1'b1;
			end
		end

		if (state_q == ST_VEC && cd_done) begin
			md_mode_q <= MD_TO_DIR;
			md_opd_q  <= cd_z[ZW-1] ? '0 : cd_z[MD_QW-1:0];
		end

		if (state_q == ST_PHI && md_done) begin
			phi_q <= (md_quo > MD_QW'(PHI_RIGHT)) ? PHI_RIGHT : md_quo[17:0];
		end

		if (state_q == ST_QUAD) begin
			res_dir_q <= d_fin;
		end

		if (state_q == ST_OUT && out_free) begin
			out_dir_q <= res_dir_q;
			out_ok_q  <= res_ok_q;
		end
	end

	// ---------------------------------------------------------------------------
	// Serial units.
	// ---------------------------------------------------------------------------
	assign md_ctl.start = md_start_q;
	assign md_ctl.mode  = md_mode_q;

	ewcm_muldiv u_muldiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (md_ctl),
		.operand  (md_opd_q),
		.done     (md_done),
		.quotient (md_quo)
	);

	assign cd_ctl.start     = cd_start_q;
	assign cd_ctl.vectoring = cd_vec_q;
	assign cd_x0 = cd_vec_q ? $signed({{(CW-MAG_W){1'b0}}, ax_q}) : GAIN_Q30;
	assign cd_y0 = cd_vec_q ? $signed({{(CW-MAG_W){1'b0}}, ay_q}) : '0;
	assign cd_z0 = cd_vec_q ? '0 : $signed({{(ZW-MD_QW){1'b0}}, md_quo});

	ewcm_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (cd_ctl),
		.x0     (cd_x0),
		.y0     (cd_y0),
		.z0     (cd_z0),
		.done   (cd_done),
		.x      (cd_x),
		.y      (cd_y),
		.z      (cd_z)
	);

	assign mac_clear = (state_q == ST_LAST) && last_q;

	ewcm_wmac u_wmac (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (mac_start_q),
		.clear      (mac_clear),
		.height     (h_q),
		.sin_v      (s_q),
		.cos_v      (c_q),
		.done       (mac_done),
		.sine_sum   (sine_sum),
		.cosine_sum (cosine_sum)
	);

	// ---------------------------------------------------------------------------
	// Ports.
	// ---------------------------------------------------------------------------
	assign samples.ready          = (state_q == ST_IDLE);
	assign result.valid           = out_valid_q;
	assign result.direction       = out_dir_q;
	assign result.direction_valid = out_ok_q;

endmodule

### dv/testbench.sv
// Self-checking testbench for energy_weighted_circular_mean_core.
// Depends on ewcm_pkg, ewcm_in_if, ewcm_out_if and the core with its sub-modules.
// Directed table first, then random runs of samples under changing idling and thresholds.
module testbench
	import ewcm_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [15:0] height;
		logic        height_valid;
		logic [15:0] angle;
		logic        angle_valid;
		logic        last_sample;
	} sample_t;

	typedef struct {
		logic [15:0] direction;
		logic        direction_valid;
	} heading_t;

	// One row of the directed table: a sample and, where it is obvious, the heading it closes.
	typedef struct {
		sample_t  smp;
		bit       fixed;
		heading_t want;
	} row_t;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE_CYCLES  = 300;
	localparam int HOLD_CYCLES    = 3000;

	localparam longint ATAN_Q24 [18] = '{
		13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
		65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128
	};

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CNT_W-1:0] cfg_wdata;

	ewcm_in_if  samples ();
	ewcm_out_if result ();

	energy_weighted_circular_mean_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.samples   (samples.sink),
		.result    (result.source)
	);

	// Shadow state of the core.
	longint   sin_acc;
	longint   cos_acc;
	int       n_usable;
	int       min_hours;

	heading_t headings_due [$];
	int       errors = 0;
	int       src_idle_pct;
	int       snk_idle_pct;
	bit       hold_req;
	int       quiet_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic int q15_round(input longint v);
		longint r;
		r = (v < 0) ? 0 : v;
		r = (r + 16384) >>> 15;
		if (r > 32767)
			r = 32767;
		return int'(r);
	endfunction

	// Rotation CORDIC on the remainder within the quadrant, signs restored afterwards.
	task automatic unit_vector(input int unsigned a, output int s, output int c);
		int unsigned q, r;
		longint x, y, z, dx, dy;
		int ps, pc;
		q = a / 9000;
		r = a % 9000;
		z = (longint'(r) * 64'sd1686629713 + 288000) / 576000;
		x = 652032874;
		y = 0;
		for (int i = 0; i < 18; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= ATAN_Q24[i];
			end else begin
				x += dx; y -= dy; z += ATAN_Q24[i];
			end
		end
		ps = q15_round(y);
		pc = q15_round(x);
		case (q)
			0: begin s = ps;  c = pc;  end
			1: begin s = pc;  c = -ps; end
			2: begin s = -ps; c = -pc; end
			default: begin s = -pc; c = ps; end
		endcase
	endtask

	// Vectoring CORDIC on the magnitudes, then placed in the quadrant of the sums.
	function automatic int bearing_of(input longint ys, input longint xs);
		bit [63:0] ay, ax;
		longint x, y, z, dx, dy;
		longint phi16, d16, d;
		ay = (ys < 0) ? -ys : ys;
		ax = (xs < 0) ? -xs : xs;
		if (ax == 0 && ay == 0)
			return 0;
		if (ay == 0) begin
			phi16 = 0;
		end else if (ax == 0) begin
			phi16 = 144000;
		end else begin
			while ((ax | ay) < (64'd1 << 54)) begin
				ax <<= 1;
				ay <<= 1;
			end
			x = ax;
			y = ay;
			z = 0;
			for (int i = 0; i < 18; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (y >= 0) begin
					x += dx; y -= dy; z += ATAN_Q24[i];
				end else begin
					x -= dx; y += dy; z -= ATAN_Q24[i];
				end
			end
			if (z < 0)
				z = 0;
			phi16 = z * 9216000 / 64'sd1686629713;
			if (phi16 > 144000)
				phi16 = 144000;
		end
		if (xs >= 0 && ys >= 0)
			d16 = phi16;
		else if (xs < 0 && ys >= 0)
			d16 = 288000 - phi16;
		else if (xs < 0)
			d16 = 288000 + phi16;
		else
			d16 = 576000 - phi16;
		d = (d16 + 8) >>> 4;
		if (d >= 36000)
			d -= 36000;
		return int'(d);
	endfunction

	// Folds one accepted sample into the shadow sums; returns 1 with the heading on a last sample.
	task automatic accumulate(input sample_t smp, output bit closed, output heading_t hd);
		int s, c;
		longint w;
		closed = 1'b0;
		hd.direction = '0;
		hd.direction_valid = 1'b0;
		if (smp.height_valid && smp.angle_valid && n_usable < 255) begin
			unit_vector(int'(smp.angle) % 36000, s, c);
			w = longint'(smp.height) * longint'(smp.height);
			sin_acc += w * s;
			cos_acc += w * c;
			n_usable++;
		end
		if (smp.last_sample) begin
			closed = 1'b1;
			if (n_usable >= min_hours) begin
				hd.direction = 16'(bearing_of(sin_acc, cos_acc));
				hd.direction_valid = 1'b1;
			end
			sin_acc = 0;
			cos_acc = 0;
			n_usable = 0;
		end
	endtask

	// Offers one sample and waits for the core to take it. valid stays high on return, so
	// back-to-back requests never lower and raise it in the same step.
	task automatic offer(input sample_t smp, input bit fixed, input heading_t want);
		bit closed;
		heading_t hd;
		if ($urandom_range(0, 99) < src_idle_pct) begin
			samples.valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(0, 99) < src_idle_pct)
				@(posedge clk);
		end
		samples.valid        <= 1'b1;
		samples.height       <= smp.height;
		samples.height_valid <= smp.height_valid;
		samples.angle        <= smp.angle;
		samples.angle_valid  <= smp.angle_valid;
		samples.last_sample  <= smp.last_sample;
		do
			@(posedge clk);
		while (!samples.ready);
		accumulate(smp, closed, hd);
		if (closed) begin
			if (fixed)
				headings_due = {headings_due, want};
			else
				headings_due = {headings_due, hd};
		end
	endtask

	task automatic offer_checked(input sample_t smp);
		heading_t none;
		none.direction = '0;
		none.direction_valid = 1'b0;
		offer(smp, 1'b0, none);
	endtask

	// Waits until every heading has come back, lets the core finish any sample in flight,
	// then writes the threshold.
	task automatic set_threshold(input int value);
		samples.valid <= 1'b0;
		while (headings_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= CNT_W'(value);
		@(posedge clk);
		cfg_we    <= 1'b0;
		min_hours = value;
	endtask

	function automatic sample_t random_sample(input bit last, input bit noisy);
		sample_t smp;
		int pick;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			smp.height = 16'hFFFF;
		else if (pick == 1)
			smp.height = 16'($urandom_range(0, 15));
		else
			smp.height = 16'($urandom);
		smp.angle = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(36000, 65535))
			: 16'($urandom_range(0, 35999));
		smp.height_valid = noisy ? 1'($urandom) : ($urandom_range(0, 19) != 0);
		smp.angle_valid  = noisy ? 1'($urandom) : ($urandom_range(0, 19) != 0);
		smp.last_sample  = last;
		return smp;
	endfunction

	// Random runs: mostly short well-formed runs, some noisy ones, occasionally a long run.
	task automatic random_runs(input int n_items, input int long_len);
		int sent, len;
		bit noisy;
		sent = 0;
		while (sent < n_items) begin
			if (long_len > 0 && $urandom_range(0, 9) == 0)
				len = long_len;
			else
				len = $urandom_range(1, 12);
			noisy = ($urandom_range(0, 4) == 0);
			for (int k = 0; k < len; k++)
				offer_checked(random_sample(k == len - 1, noisy));
			sent += len;
		end
	endtask

	function automatic row_t mk_row(input int h, input bit hv, input int a, input bit av,
		input bit last, input bit fixed, input int dir, input bit ok);
		row_t r;
		r.smp.height = 16'(h);
		r.smp.height_valid = hv;
		r.smp.angle = 16'(a);
		r.smp.angle_valid = av;
		r.smp.last_sample = last;
		r.fixed = fixed;
		r.want.direction = 16'(dir);
		r.want.direction_valid = ok;
		return r;
	endfunction

	// Receiver: checks each returned heading against the oldest one due, then chooses ready.
	initial begin : receiver
		heading_t want;
		int hold;
		bit held;
		hold = 0;
		held = 1'b0;
		result.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (result.valid && result.ready) begin
				if (headings_due.size() == 0) begin
					report_mismatch("unexpected heading", result.direction, -1);
				end else begin
					want = headings_due.pop_front();
					if (result.direction !== want.direction)
						report_mismatch("direction", result.direction, want.direction);
					if (result.direction_valid !== want.direction_valid)
						report_mismatch("direction_valid", result.direction_valid,
							want.direction_valid);
				end
			end
			// A long hold-off lets the output register fill and the core back up onto its input.
			if (hold_req && !held) begin
				held = 1'b1;
				hold = HOLD_CYCLES;
			end
			if (hold > 0) begin
				hold--;
				result.ready <= 1'b0;
			end else begin
				result.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
			end
		end
	end

	// Watchdog: ends the run when nothing moves on either channel for too long.
	always @(posedge clk) begin
		if ((samples.valid && samples.ready) || (result.valid && result.ready) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin : stimulus
		row_t table_rows [$];
		arst_n        <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_wdata     <= '0;
		samples.valid <= 1'b0;
		samples.height <= '0;
		samples.height_valid <= 1'b0;
		samples.angle <= '0;
		samples.angle_valid <= 1'b0;
		samples.last_sample <= 1'b0;
		hold_req      = 1'b0;
		sin_acc       = 0;
		cos_acc       = 0;
		n_usable      = 0;
		min_hours     = 1;
		src_idle_pct  = 34;
		snk_idle_pct  = 47;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table, run with the threshold at its reset value of one.
		// An empty run after reset is too short for a valid heading.
		table_rows = {table_rows, mk_row(0, 0, 0, 0, 1, 1, 0, 0)};
		// Single samples on the four cardinal points.
		table_rows = {table_rows, mk_row(1000, 1, 0, 1, 1, 1, 0, 1)};
		table_rows = {table_rows, mk_row(65535, 1, 9000, 1, 1, 1, 9000, 1)};
		table_rows = {table_rows, mk_row(1, 1, 18000, 1, 1, 1, 18000, 1)};
		table_rows = {table_rows, mk_row(300, 1, 27000, 1, 1, 1, 27000, 1)};
		// Zero height: both sums stay zero, the heading is north but valid.
		table_rows = {table_rows, mk_row(0, 1, 4500, 1, 1, 1, 0, 1)};
		// Missing angle: the sample is skipped but still closes the run.
		table_rows = {table_rows, mk_row(65535, 1, 65535, 0, 1, 1, 0, 0)};
		// Just west of north, which may round up to a full circle and wrap.
		table_rows = {table_rows, mk_row(5000, 1, 35999, 1, 1, 0, 0, 0)};
		// Angle beyond the circle is reduced.
		table_rows = {table_rows, mk_row(1200, 1, 65535, 1, 1, 0, 0, 0)};
		table_rows = {table_rows, mk_row(500, 1, 100, 1, 0, 0, 0, 0)};
		table_rows = {table_rows, mk_row(500, 1, 35900, 1, 1, 0, 0, 0)};
		table_rows = {table_rows, mk_row(2000, 1, 12345, 1, 0, 0, 0, 0)};
		table_rows = {table_rows, mk_row(40000, 0, 200, 1, 0, 0, 0, 0)};
		table_rows = {table_rows, mk_row(800, 1, 30000, 1, 1, 0, 0, 0)};
		// Opposite directions of equal weight, nearly cancelling.
		table_rows = {table_rows, mk_row(10, 1, 4500, 1, 0, 0, 0, 0)};
		table_rows = {table_rows, mk_row(10, 1, 22500, 1, 1, 0, 0, 0)};
		table_rows = {table_rows, mk_row(65535, 1, 13500, 1, 0, 0, 0, 0)};
		table_rows = {table_rows, mk_row(65535, 1, 31500, 1, 1, 0, 0, 0)};
		foreach (table_rows[i])
			offer(table_rows[i].smp, table_rows[i].fixed, table_rows[i].want);

		// Threshold zero: every run is valid, empty runs included.
		set_threshold(0);
		random_runs(450, 0);

		// Idling swapped, a small threshold, and one long hold-off on the result side.
		src_idle_pct = 47;
		snk_idle_pct = 34;
		set_threshold($urandom_range(2, 6));
		hold_req = 1'b1;
		random_runs(450, 0);

		// Threshold at its top: only runs that reach the sample cap come back valid.
		src_idle_pct = 0;
		snk_idle_pct = 0;
		set_threshold(255);
		random_runs(400, 270);

		set_threshold($urandom_range(0, 255));
		random_runs(150, 0);

		samples.valid <= 1'b0;
		while (headings_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule

### sim.f
design/ewcm_pkg.sv
design/ewcm_in_if.sv
design/ewcm_out_if.sv
design/ewcm_muldiv.sv
design/ewcm_cordic.sv
design/ewcm_wmac.sv
design/energy_weighted_circular_mean_core.sv
dv/testbench.sv
